[hdl/multilevel_wavelet_analysis_macros.svh]
// Assertion macros for the multilevel wavelet analysis checker.
// Depends on nothing; included by the checker file.
`ifndef MULTILEVEL_WAVELET_ANALYSIS_MACROS_SVH
`define MULTILEVEL_WAVELET_ANALYSIS_MACROS_SVH

// same-cycle implication, disabled in reset
`define MWA_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, disabled in reset
`define MWA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

[hdl/mwa_pkg.sv]
// Package for the multilevel wavelet analysis block: widths, codes, taps,
// rounding. Depends on nothing.
`timescale 1ns / 1ps
package mwa_pkg;

   localparam int DEF_FRAME_LEN = 256;
   localparam int SAMPLE_W      = 16;
   localparam int COEF_W        = 24;
   localparam int BAND_W        = 4;
   localparam int LEVELS_W      = 4;
   localparam int TAP_W         = 16;
   localparam int ACC_W         = 40;
   localparam int FRAC_BITS     = 14;
   localparam int MAX_LEVELS    = 8;

   typedef enum logic [1:0] {
      REQ_PUSH  = 2'd0,
      REQ_FINAL = 2'd1,
      REQ_READ  = 2'd2,
      REQ_NOP   = 2'd3
   } req_code_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_EMPTY   = 2'd1,
      ST_DROPPED = 2'd2,
      ST_UNUSED  = 2'd3
   } status_code_type;

   typedef enum logic {
      CSR_LEVELS = 1'b0,
      CSR_FILTER = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic                start;
      logic [LEVELS_W-1:0] levels;
      logic                d4;
   } xform_cmd_type;

   function automatic logic signed [TAP_W-1:0] tap_low(input logic d4, input logic [1:0] m);
      logic signed [TAP_W-1:0] t;
      case (m)
         2'd0:    t = d4 ? 16'sd5595 : 16'sd8192;
         2'd1:    t = d4 ? 16'sd9691 : 16'sd8192;
         2'd2:    t = d4 ? 16'sd2597 : 16'sd0;
         2'd3:    t = d4 ? -16'sd1499 : 16'sd0;
         default: t = 16'sd0;
      endcase
      return t;
   endfunction

   function automatic logic signed [TAP_W-1:0] tap_high(input logic d4, input logic [1:0] m);
      logic signed [TAP_W-1:0] t;
      case (m)
         2'd0:    t = d4 ? 16'sd1499 : -16'sd8192;
         2'd1:    t = d4 ? 16'sd2597 : 16'sd8192;
         2'd2:    t = d4 ? -16'sd9691 : 16'sd0;
         2'd3:    t = d4 ? 16'sd5595 : 16'sd0;
         default: t = 16'sd0;
      endcase
      return t;
   endfunction

   // round half up, drop fraction, saturate to coefficient width
   function automatic logic signed [COEF_W-1:0] round_sat(input logic signed [ACC_W-1:0] a);
      logic signed [ACC_W-1:0]           r;
      logic signed [ACC_W-FRAC_BITS-1:0] q;
      logic signed [COEF_W-1:0]          s;
      r = a + ACC_W'(1 << (FRAC_BITS - 1));
      q = r[ACC_W-1:FRAC_BITS];
      if (q > $signed({{(ACC_W-FRAC_BITS-COEF_W+1){1'b0}}, {(COEF_W-1){1'b1}}}))
         s = {1'b0, {(COEF_W-1){1'b1}}};
      else if (q < $signed({{(ACC_W-FRAC_BITS-COEF_W+1){1'b1}}, {(COEF_W-1){1'b0}}}))
         s = {1'b1, {(COEF_W-1){1'b0}}};
      else
         s = q[COEF_W-1:0];
      return s;
   endfunction

endpackage

[hdl/multilevel_wavelet_analysis.sv]
// Top level of the multilevel wavelet analysis block: frame loading, read-out,
// register file. Depends on mwa_pkg, mwa_ram, mwa_xform.
//
//   channel  ports         direction  content
//   request  req_*         in         req_type, req_sample
//   response rsp_*         out        coefficient, band, last, status
//   config   csr_*         in         levels, filter_select
//
// Push writes the work RAM from the idle state, and an empty read is answered there;
// other reads go through the coefficient RAM via a fetch state. Transform: per
// output a MAC pass of the shared sequencer, per level a level and a flush state,
// then a final approximation copy. Requests stall during the transform and while
// a response waits. Reset clears control state only; RAM contents stay.
`timescale 1ns / 1ps
module multilevel_wavelet_analysis import mwa_pkg::*; #(
   parameter int FRAME_LEN = DEF_FRAME_LEN
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [1:0]                 req_type,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [COEF_W-1:0]   rsp_coefficient,
   output logic [BAND_W-1:0]          rsp_band,
   output logic                       rsp_last,
   output logic [1:0]                 rsp_status,
   input  logic                       csr_we,
   input  logic                       csr_index,
   input  logic [LEVELS_W-1:0]        csr_wdata
);
   localparam int AW = $clog2(FRAME_LEN);
   localparam int CW = $clog2(FRAME_LEN + 1);

   typedef enum logic [2:0] {
      S_IDLE  = 3'b001,
      S_XFORM = 3'b010,
      S_FETCH = 3'b100
   } top_state_type;

   top_state_type       st_ff, st_in;
   logic [LEVELS_W-1:0] levels_ff, levels_in;
   logic                filt_ff, filt_in;
   logic [CW-1:0]       lc_ff, lc_in, ptr_ff, ptr_in, total_ff, total_in;
   logic                rdy_ff, rdy_in, ovf_ff, ovf_in;
   logic                rv_ff, rv_in;
   logic [COEF_W-1:0]   rc_ff, rc_in;
   logic [BAND_W-1:0]   rb_ff, rb_in;
   logic                rl_ff, rl_in;
   logic [1:0]          rs_ff, rs_in;

   logic                accept, is_last;
   xform_cmd_type       cmd;
   logic [CW-1:0]       load_len, x_total;
   logic                x_done;
   logic [AW-1:0]       x_raddr, x_waddr, c_waddr, w_waddr;
   logic [COEF_W-1:0]   w_rdata, x_wdata, w_wdata;
   logic                x_we, c_we, w_we;
   logic [BAND_W+COEF_W-1:0] c_wdata, c_rdata;

   assign req_ready = (st_ff == S_IDLE) && (!rv_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign is_last   = (ptr_ff + 1'b1) >= total_ff;

   always_comb begin
      st_in     = st_ff;
      levels_in = levels_ff;
      filt_in   = filt_ff;
      lc_in     = lc_ff;
      ptr_in    = ptr_ff;
      total_in  = total_ff;
      rdy_in    = rdy_ff;
      ovf_in    = ovf_ff;
      rv_in     = rv_ff && !rsp_ready;
      rc_in     = rc_ff;
      rb_in     = rb_ff;
      rl_in     = rl_ff;
      rs_in     = rs_ff;
      cmd       = '{start: 1'b0, levels: levels_ff, d4: filt_ff};
      w_we      = 1'b0;
      w_waddr   = lc_ff[AW-1:0];
      w_wdata   = COEF_W'(req_sample);
      load_len  = lc_ff;

      if (csr_we) begin
         case (csr_index)
            CSR_LEVELS: levels_in = csr_wdata;
            CSR_FILTER: filt_in   = csr_wdata[0];
            default:    levels_in = levels_ff;
         endcase
      end

      case (st_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_type)
                  REQ_PUSH, REQ_FINAL: begin
                     if (lc_ff < CW'(FRAME_LEN)) begin
                        w_we     = 1'b1;
                        lc_in    = lc_ff + 1'b1;
                        load_len = lc_ff + 1'b1;
                     end else begin
                        ovf_in = 1'b1;
                     end
                     if (req_type == REQ_FINAL) begin
                        cmd.start = 1'b1;
                        st_in     = S_XFORM;
                     end
                  end
                  REQ_READ: begin
                     if (!rdy_ff || ptr_ff >= total_ff) begin
                        rv_in = 1'b1;
                        rc_in = '0;
                        rb_in = '0;
                        rl_in = 1'b0;
                        rs_in = ST_EMPTY;
                     end else begin
                        st_in = S_FETCH;
                     end
                  end
                  default: begin
                     st_in = S_IDLE;
                  end
               endcase
            end
         end
         S_XFORM: begin
            w_we    = x_we;
            w_waddr = x_waddr;
            w_wdata = x_wdata;
            if (x_done) begin
               total_in = x_total;
               lc_in    = '0;
               ptr_in   = '0;
               rdy_in   = (x_total != '0);
               st_in    = S_IDLE;
            end
         end
         S_FETCH: begin
            rv_in = 1'b1;
            rc_in = c_rdata[COEF_W-1:0];
            rb_in = c_rdata[BAND_W+COEF_W-1:COEF_W];
            rl_in = is_last;
            rs_in = ovf_ff ? ST_DROPPED : ST_OK;
            if (is_last) begin
               rdy_in = 1'b0;
               ovf_in = 1'b0;
               ptr_in = '0;
            end else begin
               ptr_in = ptr_ff + 1'b1;
            end
            st_in = S_IDLE;
         end
         default: begin
            st_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff     <= S_IDLE;
         levels_ff <= LEVELS_W'(3);
         filt_ff   <= 1'b0;
         lc_ff     <= '0;
         ptr_ff    <= '0;
         total_ff  <= '0;
         rdy_ff    <= 1'b0;
         ovf_ff    <= 1'b0;
         rv_ff     <= 1'b0;
      end else begin
         st_ff     <= st_in;
         levels_ff <= levels_in;
         filt_ff   <= filt_in;
         lc_ff     <= lc_in;
         ptr_ff    <= ptr_in;
         total_ff  <= total_in;
         rdy_ff    <= rdy_in;
         ovf_ff    <= ovf_in;
         rv_ff     <= rv_in;
      end
      rc_ff <= rc_in;
      rb_ff <= rb_in;
      rl_ff <= rl_in;
      rs_ff <= rs_in;
   end

   assign rsp_valid       = rv_ff;
   assign rsp_coefficient = rc_ff;
   assign rsp_band        = rb_ff;
   assign rsp_last        = rl_ff;
   assign rsp_status      = rs_ff;

   mwa_ram #(.WIDTH(COEF_W), .DEPTH(FRAME_LEN)) u_work_ram (
      .clock (clock),
      .we    (w_we),
      .waddr (w_waddr),
      .wdata (w_wdata),
      .raddr (x_raddr),
      .rdata (w_rdata)
   );

   mwa_ram #(.WIDTH(BAND_W + COEF_W), .DEPTH(FRAME_LEN)) u_coef_ram (
      .clock (clock),
      .we    (c_we),
      .waddr (c_waddr),
      .wdata (c_wdata),
      .raddr (ptr_ff[AW-1:0]),
      .rdata (c_rdata)
   );

   mwa_xform #(.FRAME_LEN(FRAME_LEN)) u_xform (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .load_len   (load_len),
      .work_raddr (x_raddr),
      .work_rdata (w_rdata),
      .work_we    (x_we),
      .work_waddr (x_waddr),
      .work_wdata (x_wdata),
      .coef_we    (c_we),
      .coef_waddr (c_waddr),
      .coef_wdata (c_wdata),
      .done       (x_done),
      .total      (x_total)
   );
endmodule

[hdl/mwa_ram.sv]
// Generic single-clock RAM, one write port, one registered read port.
// Depends on nothing.
`timescale 1ns / 1ps
module mwa_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

[hdl/mwa_xform.sv]
// Transform sequencer: multi-level filter passes over the work RAM, details
// and final approximation into the coefficient RAM. Depends on mwa_pkg.
`timescale 1ns / 1ps
module mwa_xform import mwa_pkg::*; #(
   parameter int FRAME_LEN = DEF_FRAME_LEN
) (
   input  logic                             clock,
   input  logic                             reset,
   input  xform_cmd_type                    cmd,
   input  logic [$clog2(FRAME_LEN+1)-1:0]   load_len,
   output logic [$clog2(FRAME_LEN)-1:0]     work_raddr,
   input  logic [COEF_W-1:0]                work_rdata,
   output logic                             work_we,
   output logic [$clog2(FRAME_LEN)-1:0]     work_waddr,
   output logic [COEF_W-1:0]                work_wdata,
   output logic                             coef_we,
   output logic [$clog2(FRAME_LEN)-1:0]     coef_waddr,
   output logic [BAND_W+COEF_W-1:0]         coef_wdata,
   output logic                             done,
   output logic [$clog2(FRAME_LEN+1)-1:0]   total
);
   localparam int AW = $clog2(FRAME_LEN);
   localparam int CW = $clog2(FRAME_LEN + 1);
   localparam int IW = CW + 2;

   typedef enum logic [6:0] {
      E_IDLE  = 7'b0000001,
      E_LEVEL = 7'b0000010,
      E_MAC   = 7'b0000100,
      E_FIN   = 7'b0001000,
      E_FLUSH = 7'b0010000,
      E_COPY  = 7'b0100000,
      E_DONE  = 7'b1000000
   } eng_state_type;

   eng_state_type           st_ff, st_in;
   logic [LEVELS_W-1:0]     lv_ff, lv_in, lev_ff, lev_in;
   logic                    d4_ff, d4_in;
   logic [CW-1:0]           n_ff, n_in, lim_ff, lim_in, k_ff, k_in, pos_ff, pos_in;
   logic [2:0]              ph_ff, ph_in;
   logic                    dv_ff, dv_in, pv_ff, pv_in, cv_ff, cv_in;
   logic [1:0]              dm_ff, dm_in;
   logic signed [ACC_W-1:0] acl_ff, acl_in, ach_ff, ach_in;
   logic signed [ACC_W-1:0] prl_ff, prl_in, prh_ff, prh_in;
   logic [COEF_W-1:0]       pend_ff, pend_in;

   logic [CW-1:0]           half;
   logic [2:0]              mcnt;
   logic [1:0]              mhalf;
   logic signed [IW-1:0]    idx;
   logic                    in_rng, issue;
   logic signed [COEF_W-1:0] xval, lo_val, hi_val;
   logic [LEVELS_W-1:0]     lv_sat;

   assign half   = n_ff >> 1;
   assign mcnt   = d4_ff ? 3'd4 : 3'd2;
   assign mhalf  = d4_ff ? 2'd2 : 2'd1;
   assign idx    = $signed({1'b0, k_ff, 1'b0}) + $signed({{(IW-3){1'b0}}, ph_ff})
                 - $signed({{(IW-2){1'b0}}, mhalf});
   assign in_rng = !idx[IW-1] && (idx[IW-2:0] < {1'b0, lim_ff});
   assign issue  = (st_ff == E_MAC) && (ph_ff < mcnt);
   assign xval   = dv_ff ? $signed(work_rdata) : '0;
   assign lo_val = round_sat(acl_ff);
   assign hi_val = round_sat(ach_ff);
   assign lv_sat = (cmd.levels == '0) ? LEVELS_W'(1) :
                   (cmd.levels > LEVELS_W'(MAX_LEVELS)) ? LEVELS_W'(MAX_LEVELS) : cmd.levels;

   assign work_raddr = (st_ff == E_COPY) ? k_ff[AW-1:0] : idx[AW-1:0];
   assign done       = (st_ff == E_DONE);
   assign total      = pos_ff;

   always_comb begin
      st_in   = st_ff;
      lv_in   = lv_ff;
      lev_in  = lev_ff;
      d4_in   = d4_ff;
      n_in    = n_ff;
      lim_in  = lim_ff;
      k_in    = k_ff;
      pos_in  = pos_ff;
      ph_in   = ph_ff;
      pv_in   = pv_ff;
      cv_in   = 1'b0;
      pend_in = pend_ff;
      dv_in   = issue && in_rng;
      dm_in   = ph_ff[1:0];
      prl_in  = tap_low(d4_ff, dm_ff) * xval;
      prh_in  = tap_high(d4_ff, dm_ff) * xval;
      acl_in  = acl_ff;
      ach_in  = ach_ff;
      work_we    = 1'b0;
      work_waddr = k_ff[AW-1:0];
      work_wdata = pend_ff;
      coef_we    = 1'b0;
      coef_waddr = pos_ff[AW-1:0];
      coef_wdata = {lev_ff, hi_val};

      case (st_ff)
         E_IDLE: begin
            if (cmd.start) begin
               lv_in  = lv_sat;
               d4_in  = cmd.d4;
               lev_in = '0;
               n_in   = CW'(FRAME_LEN);
               lim_in = load_len;
               pos_in = '0;
               st_in  = E_LEVEL;
            end
         end
         E_LEVEL: begin
            k_in  = '0;
            ph_in = '0;
            pv_in = 1'b0;
            if (lev_ff == lv_ff) begin
               st_in = E_COPY;
            end else if (half == '0) begin
               n_in   = half;
               lim_in = half;
               lev_in = lev_ff + 1'b1;
            end else begin
               st_in = E_MAC;
            end
         end
         E_MAC: begin
            if (ph_ff == 3'd0) begin
               acl_in = '0;
               ach_in = '0;
            end else if (ph_ff >= 3'd2) begin
               acl_in = acl_ff + prl_ff;
               ach_in = ach_ff + prh_ff;
            end
            ph_in = ph_ff + 1'b1;
            if (ph_ff == mcnt + 3'd1) begin
               st_in = E_FIN;
            end
         end
         E_FIN: begin
            coef_we = 1'b1;
            pos_in  = pos_ff + 1'b1;
            work_we    = pv_ff;
            work_waddr = AW'(k_ff - 1'b1);
            pend_in = lo_val;
            pv_in   = 1'b1;
            ph_in   = '0;
            if (k_ff + 1'b1 == half) begin
               st_in = E_FLUSH;
            end else begin
               k_in  = k_ff + 1'b1;
               st_in = E_MAC;
            end
         end
         E_FLUSH: begin
            work_we = 1'b1;
            n_in    = half;
            lim_in  = half;
            lev_in  = lev_ff + 1'b1;
            st_in   = E_LEVEL;
         end
         E_COPY: begin
            coef_we    = cv_ff;
            coef_wdata = {lv_ff, work_rdata};
            if (cv_ff) begin
               pos_in = pos_ff + 1'b1;
            end
            if (k_ff < n_ff) begin
               cv_in = 1'b1;
               k_in  = k_ff + 1'b1;
            end else if (!cv_ff) begin
               st_in = E_DONE;
            end
         end
         E_DONE: begin
            st_in = E_IDLE;
         end
         default: begin
            st_in = E_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= E_IDLE;
         pv_ff <= 1'b0;
         cv_ff <= 1'b0;
         dv_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         pv_ff <= pv_in;
         cv_ff <= cv_in;
         dv_ff <= dv_in;
      end
      lv_ff   <= lv_in;
      lev_ff  <= lev_in;
      d4_ff   <= d4_in;
      n_ff    <= n_in;
      lim_ff  <= lim_in;
      k_ff    <= k_in;
      pos_ff  <= pos_in;
      ph_ff   <= ph_in;
      dm_ff   <= dm_in;
      prl_ff  <= prl_in;
      prh_ff  <= prh_in;
      acl_ff  <= acl_in;
      ach_ff  <= ach_in;
      pend_ff <= pend_in;
   end
endmodule

[hdl/mwa_checker.sv]
// Port-level checker for the multilevel wavelet analysis block, bound to the
// top level. Depends on mwa_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "multilevel_wavelet_analysis_macros.svh"
module mwa_checker import mwa_pkg::*; (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic signed [COEF_W-1:0]   rsp_coefficient,
   input logic [BAND_W-1:0]          rsp_band,
   input logic                       rsp_last,
   input logic [1:0]                 rsp_status
);
   `MWA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_coefficient) && $stable(rsp_status))
   `MWA_ASSERT_NOW(a_empty_zero, clock, reset, rsp_valid && rsp_status == ST_EMPTY, rsp_coefficient == '0 && rsp_band == '0 && !rsp_last)
   `MWA_ASSERT_NOW(a_no_ready_stalled, clock, reset, rsp_valid && !rsp_ready, !req_ready)
   `MWA_ASSERT_NOW(a_status_code, clock, reset, rsp_valid, rsp_status != ST_UNUSED)
endmodule

bind multilevel_wavelet_analysis mwa_checker u_mwa_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_coefficient (rsp_coefficient),
   .rsp_band        (rsp_band),
   .rsp_last        (rsp_last),
   .rsp_status      (rsp_status)
);
